@@ rtl/free_block_bitmap_allocator_core_macros.svh @@
// Assertion macros for the free-block bitmap allocator.
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// cons must hold in the same cycle as ante
`define FBBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// cons must hold in the cycle after ante
`define FBBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FBBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define FBBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/fbba_pkg.sv @@
`default_nettype none

package fbba_pkg;

   localparam int unsigned BLOCK_W          = 15;
   localparam int unsigned OP_W             = 2;
   localparam int unsigned WORD_W           = 64;
   localparam int unsigned WORD_IDX_W       = 6;
   localparam int unsigned ADDR_SPACE       = 32768;
   localparam int unsigned DEF_TOTAL_BLOCKS = 32768;
   localparam logic [BLOCK_W-1:0] SEARCH_START_RST = 15'd1040;

   typedef enum logic [OP_W-1:0] {
      OP_FIND = 2'd0,
      OP_SET  = 2'd1,
      OP_CLR  = 2'd2
   } opcode_type;

   typedef struct packed {
      logic clr;
      logic load;
      logic rd;
      logic wr;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_end;
      logic clr_last;
      logic req_mark_ok;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/fbba_datapath.sv @@
`default_nettype none

module fbba_datapath
   import fbba_pkg::*;
#(
   parameter int unsigned TOTAL_BLOCKS = DEF_TOTAL_BLOCKS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [OP_W-1:0]    req_opcode,
   input  wire logic [BLOCK_W-1:0] req_block_number,
   input  wire logic               csr_valid,
   input  wire logic [BLOCK_W-1:0] csr_search_start,
   input  wire cmd_type            cmd,
   output status_type              status,
   output logic                    rsp_found,
   output logic [BLOCK_W-1:0]      rsp_result_block
);

   localparam int unsigned LIMIT     = (TOTAL_BLOCKS < ADDR_SPACE) ? TOTAL_BLOCKS : ADDR_SPACE;
   localparam int unsigned DEPTH     = (LIMIT + WORD_W - 1) / WORD_W;
   localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned TAIL_BITS = LIMIT - (DEPTH - 1) * WORD_W;
   localparam logic [WORD_W-1:0]  TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL_BITS);
   localparam logic [BLOCK_W:0]   LIMIT_V   = (BLOCK_W + 1)'(LIMIT);
   localparam logic [AW-1:0]      LAST_WORD = AW'(DEPTH - 1);

   logic [WORD_W-1:0]  mem [0:DEPTH-1];

   logic [BLOCK_W-1:0] search_start_ff;
   logic [OP_W-1:0]    op_ff;
   logic [BLOCK_W-1:0] blk_ff;
   logic               mark_ok_ff;
   logic [AW-1:0]      sw_ff;
   logic [2:0]         lo_ff;
   logic [AW-1:0]      addr_ff;
   logic [AW-1:0]      addr_in;
   logic               more_ff;
   logic               pend_ff;
   logic [AW-1:0]      ev_addr_ff;
   logic [WORD_W-1:0]  rdata_ff;
   logic               found_ff;
   logic [BLOCK_W-1:0] result_ff;

   logic [BLOCK_W-1:0]    start8;
   logic                  start_ok;
   logic [WORD_W-1:0]     lo_mask;
   logic [WORD_W-1:0]     free_bits;
   logic [WORD_IDX_W-1:0] hit_idx;
   logic [WORD_W-1:0]     bit_sel;
   logic [WORD_W-1:0]     wdata;
   logic                  addr_last;

   assign start8    = {search_start_ff[BLOCK_W-1:3], 3'b000};
   assign start_ok  = {1'b0, start8} < LIMIT_V;
   assign lo_mask   = {WORD_W{1'b1}} << {lo_ff, 3'b000};
   assign addr_last = (addr_ff == LAST_WORD);
   assign addr_in   = addr_last ? '0 : addr_ff + AW'(1);

   assign free_bits = ~rdata_ff
                    & ((ev_addr_ff == sw_ff) ? lo_mask : {WORD_W{1'b1}})
                    & ((ev_addr_ff == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}});

   always_comb begin
      hit_idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            hit_idx = WORD_IDX_W'(i);
         end
      end
   end

   assign bit_sel = WORD_W'(1) << blk_ff[WORD_IDX_W-1:0];
   assign wdata   = (op_ff == OP_SET) ? (rdata_ff | bit_sel) : (rdata_ff & ~bit_sel);

   assign status.scan_hit    = pend_ff && (|free_bits);
   assign status.scan_end    = pend_ff ? (ev_addr_ff == LAST_WORD) : !more_ff;
   assign status.clr_last    = addr_last;
   assign status.req_mark_ok = {1'b0, req_block_number} < LIMIT_V;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_start_ff <= SEARCH_START_RST;
      end else if (csr_valid) begin
         search_start_ff <= csr_search_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         more_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else if (cmd.clr) begin
         addr_ff <= addr_in;
      end else if (cmd.load) begin
         if (req_opcode == OP_FIND) begin
            addr_ff <= search_start_ff[WORD_IDX_W +: AW];
            more_ff <= start_ok;
         end else begin
            addr_ff <= req_block_number[WORD_IDX_W +: AW];
            more_ff <= 1'b1;
         end
         pend_ff <= 1'b0;
      end else if (cmd.rd) begin
         pend_ff <= more_ff;
         if (more_ff) begin
            addr_ff <= addr_in;
            more_ff <= !addr_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         blk_ff     <= req_block_number;
         mark_ok_ff <= status.req_mark_ok;
         sw_ff      <= search_start_ff[WORD_IDX_W +: AW];
         lo_ff      <= search_start_ff[5:3];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd && more_ff) begin
         rdata_ff   <= mem[addr_ff];
         ev_addr_ff <= addr_ff;
      end
      if (cmd.clr) begin
         mem[addr_ff] <= '0;
      end else if (cmd.wr) begin
         mem[ev_addr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         unique case (op_ff) inside
            OP_FIND: begin
               found_ff  <= status.scan_hit;
               result_ff <= status.scan_hit ? BLOCK_W'({ev_addr_ff, hit_idx}) : '0;
            end
            OP_SET, OP_CLR: begin
               found_ff  <= mark_ok_ff;
               result_ff <= blk_ff;
            end
            default: begin
               found_ff  <= 1'b0;
               result_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_found        = found_ff;
   assign rsp_result_block = result_ff;

endmodule

`default_nettype wire

@@ rtl/fbba_ctrl.sv @@
`default_nettype none

`include "free_block_bitmap_allocator_core_macros.svh"

module fbba_ctrl
   import fbba_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [OP_W-1:0] req_opcode,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire status_type      status,
   output cmd_type              cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FIND,
      S_MREAD,
      S_MWRITE,
      S_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.clr  = (state_ff == S_CLEAR);
      cmd.load = accept;
      cmd.rd   = (state_ff == S_FIND) || (state_ff == S_MREAD);
      cmd.wr   = (state_ff == S_MWRITE);
      cmd.fin  = 1'b0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_FIND) begin
                  state_in = S_FIND;
               end else if ((req_opcode == OP_SET || req_opcode == OP_CLR)
                            && status.req_mark_ok) begin
                  state_in = S_MREAD;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIND: begin
            if (status.scan_hit || status.scan_end) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MREAD: begin
            state_in = S_MWRITE;
         end
         S_MWRITE: begin
            cmd.fin  = 1'b1;
            state_in = S_IDLE;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.fin || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // result slot must be empty when a beat completes
   `FBBA_ASSERT_NOW(a_fin_slot_free, clock, reset, cmd.fin, !rsp_valid_ff, "finish over pending result")
   `FBBA_ASSERT_NEXT(a_one_at_a_time, clock, reset, accept, !req_ready, "second item taken while busy")
   `FBBA_ASSERT_NOW(a_write_after_read, clock, reset, cmd.wr, $past(cmd.rd), "mark write without read")
   `FBBA_ASSERT_NEXT(a_hit_reported, clock, reset, (state_ff == S_FIND) && status.scan_hit, rsp_valid_ff, "find hit not reported")

endmodule

`default_nettype wire

@@ rtl/free_block_bitmap_allocator_core.sv @@
// Channel   Ports                                            Direction
// req       req_valid/ready, req_opcode, req_block_number    in
// rsp       rsp_valid/ready, rsp_found, rsp_result_block     out
// csr       csr_valid/ready, csr_search_start                in
//
// After reset a clearing pass zeroes the bitmap, one 64-bit word a cycle;
// no req beat is taken until it ends.
// Find: scans bitmap words from the search-start word up to the last word, stopping at the first free block.
// Mark: read then write of one word. Bad opcode or range: finishes without touching the bitmap.
// One item at a time; a new req beat waits until the previous rsp is taken.
`default_nettype none

module free_block_bitmap_allocator_core
   import fbba_pkg::*;
#(
   parameter int unsigned TOTAL_BLOCKS = DEF_TOTAL_BLOCKS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [OP_W-1:0]    req_opcode,
   input  wire logic [BLOCK_W-1:0] req_block_number,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_found,
   output logic [BLOCK_W-1:0]      rsp_result_block,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [BLOCK_W-1:0] csr_search_start
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   fbba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   fbba_datapath #(
      .TOTAL_BLOCKS (TOTAL_BLOCKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_block_number (req_block_number),
      .csr_valid        (csr_valid),
      .csr_search_start (csr_search_start),
      .cmd              (cmd),
      .status           (status),
      .rsp_found        (rsp_found),
      .rsp_result_block (rsp_result_block)
   );

endmodule

`default_nettype wire
